@@ rtl/ovst_pkg.sv @@
// Package for the ordered value set table.
// Request and status codes, sequencer phases and the per-cell control bundle.
// No dependencies.
package ovst_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ECOUNT_W = 7;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_EXEC = 1'b1
  } phase_t;

  // control that the sequencer drives into each cell
  typedef struct packed {
    logic cmp;       // latch compare of probe against entry
    logic occupied;  // cell lies below the fill count
    logic remove;    // remove pass: cells at or past the first hit take from above
    logic load;      // write probe into this cell
  } cell_ctrl_t;

endpackage

@@ rtl/ordered_value_set_table.sv @@
// Top level of the ordered value set table: sequencer, fill count and cell chain.
// Depends on ovst_pkg and ovst_cell.
//
//   channel  | handshake          | fields
//   ---------+--------------------+--------------------------------
//   request  | start, busy        | mode, value
//   result   | done (one cycle)   | status, entry_count, is_empty
//
// Per request: the accept edge latches every cell's compare, then the
// execute phase runs the first-hit chain and the shift or append. busy is high
// during the execute phase only. The result sits on the ports for one cycle
// with done, while the next request may already be taken. rst clears the
// count and the sequencer; entries are garbage until written.
module ordered_value_set_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ovst_pkg::MODE_W-1:0]       mode,
  input  logic signed [ovst_pkg::VALUE_W-1:0] value,
  output logic                              done,
  output logic [ovst_pkg::STATUS_W-1:0]     status,
  output logic [ovst_pkg::ECOUNT_W-1:0]     entry_count,
  output logic                              is_empty
);
  import ovst_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  phase_t phase, phase_next;
  logic   accept, exec;

  logic [CNT_W-1:0]   count, count_next;
  logic [MODE_W-1:0]  req_mode;
  logic [VALUE_W-1:0] req_value;
  logic [VALUE_W-1:0] probe;
  status_t            status_next;
  logic               full, found;

  logic [VALUE_W-1:0] ent [TABLE_DEPTH];
  logic [VALUE_W-1:0] up  [TABLE_DEPTH];
  logic [TABLE_DEPTH:0] hit;

  assign accept = start && !busy;

  // sequencer
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: if (start) phase_next = PH_EXEC;
      PH_EXEC: phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        busy = 1'b0;
        exec = 1'b0;
      end
      PH_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode  <= mode;
      req_value <= value;
    end
  end

  // compare against the incoming value, load with the latched one
  assign probe = busy ? req_value : value;

  // cell chain
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;

    assign ctrl.cmp      = accept;
    assign ctrl.occupied = CNT_W'(i) < count;
    assign ctrl.remove   = exec && (req_mode == MODE_REMOVE);
    assign ctrl.load     = exec && (req_mode == MODE_APPEND) && !full
                           && (CNT_W'(i) == count);

    if (i == TABLE_DEPTH - 1) begin : g_top
      assign up[i] = ent[i];
    end else begin : g_mid
      assign up[i] = ent[i + 1];
    end

    ovst_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .probe    (probe),
      .entry_up (up[i]),
      .hit_in   (hit[i]),
      .hit_out  (hit[i + 1]),
      .entry    (ent[i])
    );
  end

  assign full  = (count == CNT_W'(TABLE_DEPTH));
  assign found = hit[TABLE_DEPTH];

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    unique case (req_mode)
      MODE_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      MODE_QUERY: begin
        status_next = found ? ST_OK : ST_MISSING;
      end
      MODE_REMOVE: begin
        if (found) begin
          count_next = count - 1'b1;
        end else begin
          status_next = ST_MISSING;
        end
      end
      default: begin
        // unused code: table untouched
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= exec;
      if (exec) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status      <= status_next;
      entry_count <= ECOUNT_W'(count_next);
      is_empty    <= (count_next == '0);
    end
  end

  // a result beat only follows an execute cycle
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without an execute cycle");

  // an accepted request always goes to execute next
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not execute");

  // the fill count never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("fill count above capacity");

  // a dropped append leaves a full table
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> full)
    else $error("full status with free room");

endmodule

@@ rtl/ovst_cell.sv @@
// One storage cell of the ordered value set table chain.
// Holds one entry and a match flag; passes the first-hit chain upward.
// Depends on ovst_pkg.
module ovst_cell (
  input  logic                            clk,
  input  ovst_pkg::cell_ctrl_t            ctrl,
  input  logic [ovst_pkg::VALUE_W-1:0]    probe,
  input  logic [ovst_pkg::VALUE_W-1:0]    entry_up,
  input  logic                            hit_in,
  output logic                            hit_out,
  output logic [ovst_pkg::VALUE_W-1:0]    entry
);
  import ovst_pkg::*;

  logic match;

  assign hit_out = hit_in | match;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      match <= ctrl.occupied && (entry == probe);
    end
    if (ctrl.load) begin
      entry <= probe;
    end else if (ctrl.remove && hit_out) begin
      entry <= entry_up;
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for ordered_value_set_table: directed and random append/query/remove beats
// checked against a cycle-free predictor of the table. Depends on ovst_pkg and the RTL.
module testbench;
  import ovst_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned POOL_SIZE = 12;

  typedef struct packed {
    status_t st;
    logic [ECOUNT_W-1:0] fill;
    logic empty;
  } outcome_t;

  // Predictor of the table plus the store of outcomes still owed by the block.
  class value_table_scoreboard;
    logic [VALUE_W-1:0] slots[DEPTH];
    int unsigned fill;
    outcome_t owed[$];
    int unsigned failures;
    int unsigned checked;
    int unsigned full_drops;
    int unsigned removes_hit;
    int unsigned peak_fill;

    function new();
      fill = 0;
      failures = 0;
      checked = 0;
      full_drops = 0;
      removes_hit = 0;
      peak_fill = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function void note_request(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v);
      int hit;
      outcome_t o;
      hit = -1;
      for (int i = 0; i < int'(fill); i++) begin
        if (hit < 0 && slots[i] == v) hit = i;
      end
      o.st = ST_OK;
      case (m)
        MODE_APPEND: begin
          if (fill >= DEPTH) begin
            o.st = ST_FULL;
            full_drops++;
          end else begin
            slots[fill] = v;
            fill++;
          end
        end
        MODE_QUERY: begin
          if (hit < 0) o.st = ST_MISSING;
        end
        MODE_REMOVE: begin
          if (hit < 0) begin
            o.st = ST_MISSING;
          end else begin
            // close the gap, order of later entries kept
            for (int j = hit; j + 1 < int'(fill); j++) slots[j] = slots[j + 1];
            fill--;
            removes_hit++;
          end
        end
        default: ;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      o.fill = fill[ECOUNT_W-1:0];
      o.empty = (fill == 0);
      owed.push_back(o);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [ECOUNT_W-1:0] cnt,
                               logic empty);
      outcome_t o;
      checked++;
      if (owed.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result beat: status %0d count %0d empty %0d",
                   st, cnt, empty);
        return;
      end
      o = owed.pop_front();
      if (st !== o.st || cnt !== o.fill || empty !== o.empty) begin
        failures++;
        if (failures <= 10)
          $display("result %0d: expected status %0d count %0d empty %0d, got %0d %0d %0d",
                   checked, o.st, o.fill, o.empty, st, cnt, empty);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [MODE_W-1:0] mode = MODE_APPEND;
  logic signed [VALUE_W-1:0] value = '0;
  logic busy;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [ECOUNT_W-1:0] entry_count;
  logic is_empty;

  value_table_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned sent = 0;
  logic [VALUE_W-1:0] pool[POOL_SIZE];

  ordered_value_set_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .value(value),
    .done(done),
    .status(status),
    .entry_count(entry_count),
    .is_empty(is_empty)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result checked before the request of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) sb.check_result(status, entry_count, is_empty);
      if (start && !busy) sb.note_request(mode, value);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats owed", cycles, sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v);
    @(negedge clk);
    start <= 1'b1;
    mode <= m;
    value <= v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sent++;
  endtask

  task automatic hold_off(int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [MODE_W-1:0] pick_mode(int unsigned kind);
    int unsigned r;
    r = $urandom_range(99);
    case (kind)
      0: return (r < 75) ? MODE_APPEND : (r < 90) ? MODE_QUERY :
                (r < 98) ? MODE_REMOVE : MODE_IGNORED;
      1: return (r < 15) ? MODE_APPEND : (r < 35) ? MODE_QUERY :
                (r < 98) ? MODE_REMOVE : MODE_IGNORED;
      default: return (r < 35) ? MODE_APPEND : (r < 65) ? MODE_QUERY :
                      (r < 97) ? MODE_REMOVE : MODE_IGNORED;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 85) return pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  initial begin
    int unsigned idle_pct;
    int unsigned kind;
    int unsigned seg_left;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, duplicates, misses, ignored mode, empty-table cases
    send(MODE_QUERY, 32'h0000_0000);
    send(MODE_REMOVE, 32'h0000_0000);
    send(MODE_IGNORED, 32'hFFFF_FFFF);
    send(MODE_APPEND, 32'h8000_0000);
    send(MODE_APPEND, 32'h7FFF_FFFF);
    send(MODE_APPEND, 32'h0000_0000);
    send(MODE_APPEND, 32'hFFFF_FFFF);
    send(MODE_APPEND, 32'h0000_0005);
    send(MODE_APPEND, 32'h0000_0005);
    send(MODE_QUERY, 32'h8000_0000);
    send(MODE_QUERY, 32'hFFFF_FFFF);
    send(MODE_QUERY, 32'h7FFF_FFFE);
    send(MODE_REMOVE, 32'h0000_0005);
    send(MODE_QUERY, 32'h0000_0005);
    send(MODE_REMOVE, 32'h7FFF_FFFF);
    send(MODE_REMOVE, 32'h1234_5678);
    send(MODE_IGNORED, 32'h0000_0000);
    send(MODE_QUERY, 32'h0000_0000);
    send(MODE_REMOVE, 32'h8000_0000);
    send(MODE_REMOVE, 32'h0000_0000);
    send(MODE_REMOVE, 32'hFFFF_FFFF);
    send(MODE_REMOVE, 32'h0000_0005);
    send(MODE_QUERY, 32'h0000_0005);
    drain();

    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) pool[i] = $urandom;

    // three idling profiles; segments rotate fill / drain / mixed pressure
    kind = 0;
    seg_left = 150;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 17 : (ph == 1) ? 65 : 0;
      for (int n = 0; n < 500; n++) begin
        if (seg_left == 0) begin
          kind = (kind + 1) % 3;
          seg_left = $urandom_range(40, 120);
          pool[4 + $urandom_range(POOL_SIZE - 5)] = $urandom;
        end
        seg_left--;
        send(pick_mode(kind), pick_value());
        if (n % 250 == 249) drain();
        else if ($urandom_range(99) < idle_pct) hold_off($urandom_range(1, 4));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d requests sent, %0d results checked; peak fill %0d of %0d,",
             sent, sb.checked, sb.peak_fill, DEPTH);
    $display("%0d appends dropped on a full table, %0d removes matched",
             sb.full_drops, sb.removes_hit);
    if (sb.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad result beats", sb.failures);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
